// ===== rtl/sfpb_pkg.sv =====
// Shared types, codes and reply tables for the serial flash programmer bridge.
`default_nettype none
package sfpb_pkg;

    localparam logic [1:0] ACT_HOST = 2'd0;
    localparam logic [1:0] ACT_SPI  = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    localparam logic [1:0] KIND_HOST = 2'd0;
    localparam logic [1:0] KIND_SPI  = 2'd1;
    localparam logic [1:0] KIND_CS   = 2'd2;

    localparam logic [7:0] RESP_ACK = 8'h06;
    localparam logic [7:0] RESP_NAK = 8'h15;
    localparam logic [7:0] FILL     = 8'hFF;
    localparam logic [7:0] BUS_SPI  = 8'h08;

    localparam logic [7:0] CMD_NOP     = 8'h00;
    localparam logic [7:0] CMD_IFACE   = 8'h01;
    localparam logic [7:0] CMD_CMDMAP  = 8'h02;
    localparam logic [7:0] CMD_PGMNAME = 8'h03;
    localparam logic [7:0] CMD_SERBUF  = 8'h04;
    localparam logic [7:0] CMD_BUSTYPE = 8'h05;
    localparam logic [7:0] CMD_WRNMAX  = 8'h07;
    localparam logic [7:0] CMD_RDNMAX  = 8'h0F;
    localparam logic [7:0] CMD_SETBUS  = 8'h10;
    localparam logic [7:0] CMD_OPSPI   = 8'h11;
    localparam logic [7:0] CMD_SPIFREQ = 8'h12;
    localparam logic [7:0] CMD_SPIPIN  = 8'h13;

    localparam logic [31:0] BASE_RATE = 32'd36000000;
    localparam logic [15:0] TIMEOUT_RESET = 16'd200;
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        TAIL_NONE = 2'd0,
        TAIL_MAP  = 2'd1,
        TAIL_NAME = 2'd2
    } tail_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic [2:0] clock_select;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] val;
    } res_t;

    // replies for one event: explicit items then an optional table tail
    typedef struct packed {
        logic [2:0]     n;
        tail_t          tail;
        logic [2:0]     clk;
        res_t [4:0]     items;
    } job_t;

    function automatic logic [2:0] params_needed(input logic [7:0] cmd);
        logic [2:0] r;
        r = 3'd0;
        if (cmd == CMD_SETBUS) r = 3'd1;
        if (cmd == CMD_OPSPI) r = 3'd6;
        if (cmd == CMD_SPIFREQ) r = 3'd4;
        if (cmd == CMD_SPIPIN) r = 3'd2;
        return r;
    endfunction

    function automatic logic [5:0] tail_len(input tail_t t);
        logic [5:0] r;
        unique case (t)
            TAIL_MAP:  r = 6'd32;
            TAIL_NAME: r = 6'd16;
            default:   r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] map_byte(input logic [4:0] idx);
        logic [7:0] r;
        unique case (idx)
            5'd0:    r = 8'hBF;
            5'd1:    r = 8'h80;
            5'd2:    r = 8'h0F;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] name_byte(input logic [3:0] idx);
        logic [7:0] r;
        unique case (idx)
            4'd0:    r = 8'h75;
            4'd1:    r = 8'h6E;
            4'd2:    r = 8'h69;
            4'd3:    r = 8'h2D;
            4'd4:    r = 8'h73;
            4'd5:    r = 8'h65;
            4'd6:    r = 8'h72;
            4'd7:    r = 8'h70;
            4'd8:    r = 8'h72;
            4'd9:    r = 8'h6F;
            4'd10:   r = 8'h67;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rate_of(input logic [2:0] c);
        return BASE_RATE >> c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sfpb_queue.sv =====
// Two-entry job queue between the decode front and the reply back end.
`default_nettype none
module sfpb_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  sfpb_pkg::job_t       push_data,
    output logic                 full,
    input  wire logic            pop,
    output sfpb_pkg::job_t       head,
    output logic                 not_empty
);
    import sfpb_pkg::*;

    job_t       entry_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'(QDEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

// ===== rtl/sfpb_front.sv =====
// Command decoder: takes events, keeps protocol state and write buffer, queues reply jobs.
`default_nettype none
module sfpb_front #(
    parameter int WRITE_DEPTH = 1024,
    parameter int READ_LIMIT  = 4096
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  sfpb_pkg::in_item_t   in_data,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [15:0]     cfg_data,
    input  wire logic            q_full,
    output logic                 q_push,
    output sfpb_pkg::job_t       q_data
);
    import sfpb_pkg::*;

    localparam int WL_W = $clog2(WRITE_DEPTH + 1);
    localparam int RL_W = $clog2(READ_LIMIT + 1);
    localparam int BI_W = $clog2(WRITE_DEPTH + READ_LIMIT + 1);
    localparam int AW   = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
    localparam logic [24:0] WD25 = 25'(WRITE_DEPTH);
    localparam logic [23:0] RL24 = 24'(READ_LIMIT);
    localparam logic [15:0] WD16 = 16'(WRITE_DEPTH);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_PARAMS = 4'b0010,
        PH_WDATA  = 4'b0100,
        PH_SPI    = 4'b1000
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic [2:0]        pc_reg, pc_next;
    logic [47:0]       pb_reg, pb_next;
    logic [WL_W-1:0]   wl_reg, wl_next;
    logic [RL_W-1:0]   rl_reg, rl_next;
    logic [BI_W-1:0]   bi_reg, bi_next;
    logic [15:0]       wt_reg, wt_next;
    logic              sel_reg, sel_next;
    logic [2:0]        clk_reg, clk_next;
    logic [15:0]       timeout_reg;
    logic              st_valid_reg;
    in_item_t          st_reg;

    logic [7:0]        store [WRITE_DEPTH];
    logic [7:0]        rdata_reg;
    logic [AW-1:0]     raddr;
    logic              wen;
    logic              accept;

    job_t              j;
    logic [2:0]        jn;
    logic              rc_go, ss_go, sn_go;
    logic [7:0]        rc_cmd;
    logic [2:0]        choice;
    logic [31:0]       rate;
    logic [31:0]       req;

    assign cfg_ready = 1'b1;
    assign in_stall  = st_valid_reg || q_full;
    assign accept    = in_valid && !in_stall;
    assign raddr     = (in_data.action == ACT_SPI) ? AW'(bi_reg + 1'b1) : '0;

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        pc_next    = pc_reg;
        pb_next    = pb_reg;
        wl_next    = wl_reg;
        rl_next    = rl_reg;
        bi_next    = bi_reg;
        wt_next    = wt_reg;
        sel_next   = sel_reg;
        clk_next   = clk_reg;
        j          = '0;
        jn         = 3'd0;
        wen        = 1'b0;
        rc_go      = 1'b0;
        ss_go      = 1'b0;
        sn_go      = 1'b0;
        rc_cmd     = st_reg.in_byte;
        choice     = 3'd7;
        rate       = '0;
        req        = '0;
        if (st_valid_reg)
        begin
            unique case (st_reg.action)
                ACT_HOST:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        cmd_next = st_reg.in_byte;
                        if (params_needed(st_reg.in_byte) != 3'd0)
                        begin
                            pc_next    = 3'd0;
                            pb_next    = '0;
                            wt_next    = '0;
                            phase_next = PH_PARAMS;
                        end
                        else
                            rc_go = 1'b1;
                    end
                    else if (phase_reg == PH_PARAMS)
                    begin
                        if (pc_reg < 3'd6)
                            pb_next = pb_reg | (48'(st_reg.in_byte) << {pc_reg, 3'b000});
                        pc_next = pc_reg + 3'd1;
                        wt_next = '0;
                        if (pc_next >= params_needed(cmd_reg))
                        begin
                            rc_go  = 1'b1;
                            rc_cmd = cmd_reg;
                        end
                    end
                    else if (phase_reg == PH_WDATA)
                    begin
                        wen     = 1'b1;
                        bi_next = bi_reg + 1'b1;
                        wt_next = '0;
                        if (bi_next >= BI_W'(wl_reg))
                            ss_go = 1'b1;
                    end
                end
                ACT_SPI:
                begin
                    if (phase_reg == PH_SPI)
                    begin
                        if (bi_reg >= BI_W'(wl_reg))
                        begin
                            j.items[jn] = '{KIND_HOST, st_reg.in_byte};
                            jn = jn + 3'd1;
                        end
                        bi_next = bi_reg + 1'b1;
                        sn_go   = 1'b1;
                    end
                end
                ACT_TICK:
                begin
                    if (phase_reg == PH_PARAMS || phase_reg == PH_WDATA)
                    begin
                        if (wt_reg != 16'hFFFF)
                            wt_next = wt_reg + 16'd1;
                        if (wt_next >= timeout_reg)
                        begin
                            j.items[jn] = '{KIND_HOST, RESP_NAK};
                            jn = jn + 3'd1;
                            phase_next = PH_IDLE;
                            wt_next    = '0;
                        end
                    end
                end
                default: ;
            endcase

            if (rc_go)
            begin
                phase_next = PH_IDLE;
                priority if (rc_cmd == CMD_NOP)
                begin
                    j.items[0] = '{KIND_HOST, RESP_ACK};
                    jn = 3'd1;
                end
                else if (rc_cmd == CMD_IFACE)
                begin
                    j.items[0] = '{KIND_HOST, RESP_ACK};
                    j.items[1] = '{KIND_HOST, 8'h01};
                    j.items[2] = '{KIND_HOST, 8'h00};
                    jn = 3'd3;
                end
                else if (rc_cmd == CMD_CMDMAP)
                begin
                    j.items[0] = '{KIND_HOST, RESP_ACK};
                    jn = 3'd1;
                    j.tail = TAIL_MAP;
                end
                else if (rc_cmd == CMD_PGMNAME)
                begin
                    j.items[0] = '{KIND_HOST, RESP_ACK};
                    jn = 3'd1;
                    j.tail = TAIL_NAME;
                end
                else if (rc_cmd == CMD_SERBUF)
                begin
                    j.items[0] = '{KIND_HOST, RESP_ACK};
                    j.items[1] = '{KIND_HOST, RL24[7:0]};
                    j.items[2] = '{KIND_HOST, RL24[15:8]};
                    jn = 3'd3;
                end
                else if (rc_cmd == CMD_BUSTYPE)
                begin
                    j.items[0] = '{KIND_HOST, RESP_ACK};
                    j.items[1] = '{KIND_HOST, BUS_SPI};
                    jn = 3'd2;
                end
                else if (rc_cmd == CMD_WRNMAX)
                begin
                    j.items[0] = '{KIND_HOST, RESP_ACK};
                    j.items[1] = '{KIND_HOST, WD16[7:0]};
                    j.items[2] = '{KIND_HOST, WD16[15:8]};
                    jn = 3'd3;
                end
                else if (rc_cmd == CMD_RDNMAX)
                begin
                    j.items[0] = '{KIND_HOST, RESP_ACK};
                    j.items[1] = '{KIND_HOST, RL24[7:0]};
                    j.items[2] = '{KIND_HOST, RL24[15:8]};
                    j.items[3] = '{KIND_HOST, RL24[23:16]};
                    jn = 3'd4;
                end
                else if (rc_cmd == CMD_SETBUS)
                begin
                    j.items[0] = '{KIND_HOST, pb_next[3] ? RESP_ACK : RESP_NAK};
                    jn = 3'd1;
                end
                else if (rc_cmd == CMD_OPSPI)
                begin
                    if ({1'b0, pb_next[23:0]} > WD25 || pb_next[47:24] > RL24)
                    begin
                        wl_next = '0;
                        rl_next = '0;
                        j.items[0] = '{KIND_HOST, RESP_NAK};
                        jn = 3'd1;
                    end
                    else
                    begin
                        wl_next = WL_W'(pb_next[23:0]);
                        rl_next = RL_W'(pb_next[47:24]);
                        if (pb_next[23:0] != 24'd0)
                        begin
                            bi_next    = '0;
                            wt_next    = '0;
                            phase_next = PH_WDATA;
                        end
                        else
                            ss_go = 1'b1;
                    end
                end
                else if (rc_cmd == CMD_SPIFREQ)
                begin
                    req = pb_next[31:0];
                    for (int i = 7; i >= 0; i--)
                    begin
                        if (rate_of(3'(i)) <= req)
                            choice = 3'(i);
                    end
                    clk_next = choice;
                    rate = rate_of(choice);
                    j.items[0] = '{KIND_HOST, RESP_ACK};
                    j.items[1] = '{KIND_HOST, rate[7:0]};
                    j.items[2] = '{KIND_HOST, rate[15:8]};
                    j.items[3] = '{KIND_HOST, rate[23:16]};
                    j.items[4] = '{KIND_HOST, rate[31:24]};
                    jn = 3'd5;
                end
                else if (rc_cmd == CMD_SPIPIN)
                begin
                    if (pb_next[7:0] == 8'd0)
                    begin
                        sel_next = (pb_next[15:8] != 8'd0);
                        j.items[jn] = '{KIND_CS, {7'd0, sel_next}};
                        jn = jn + 3'd1;
                    end
                    j.items[jn] = '{KIND_HOST, RESP_ACK};
                    jn = jn + 3'd1;
                end
                else
                begin
                    j.items[0] = '{KIND_HOST, RESP_NAK};
                    jn = 3'd1;
                end
            end

            if (ss_go)
            begin
                j.items[jn] = '{KIND_HOST, RESP_ACK};
                jn = jn + 3'd1;
                sel_next = 1'b0;
                j.items[jn] = '{KIND_CS, 8'd0};
                jn = jn + 3'd1;
                bi_next    = '0;
                phase_next = PH_SPI;
                sn_go      = 1'b1;
            end

            if (sn_go)
            begin
                // a one-byte write is still in the event stage, not yet in the buffer
                priority if (bi_next < BI_W'(wl_next))
                    j.items[jn] = '{KIND_SPI, (wen && bi_reg == '0) ? st_reg.in_byte : rdata_reg};
                else if (bi_next < BI_W'(wl_next) + BI_W'(rl_next))
                    j.items[jn] = '{KIND_SPI, FILL};
                else
                begin
                    sel_next    = 1'b1;
                    j.items[jn] = '{KIND_CS, 8'd1};
                    phase_next  = PH_IDLE;
                end
                jn = jn + 3'd1;
            end
        end
        j.n   = jn;
        j.clk = clk_next;
    end

    assign q_push = st_valid_reg && (jn != 3'd0);
    assign q_data = j;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            cmd_reg      <= '0;
            pc_reg       <= '0;
            pb_reg       <= '0;
            wl_reg       <= '0;
            rl_reg       <= '0;
            bi_reg       <= '0;
            wt_reg       <= '0;
            sel_reg      <= 1'b1;
            clk_reg      <= 3'd1;
            timeout_reg  <= TIMEOUT_RESET;
            st_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            cmd_reg      <= cmd_next;
            pc_reg       <= pc_next;
            pb_reg       <= pb_next;
            wl_reg       <= wl_next;
            rl_reg       <= rl_next;
            bi_reg       <= bi_next;
            wt_reg       <= wt_next;
            sel_reg      <= sel_next;
            clk_reg      <= clk_next;
            st_valid_reg <= accept;
            if (cfg_valid && cfg_ready)
                timeout_reg <= cfg_data;
        end
    end

    // event stage and write buffer; the read for the next SPI byte is issued at the transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_reg    <= in_data;
            rdata_reg <= store[raddr];
        end
        if (wen)
            store[bi_reg[AW-1:0]] <= st_reg.in_byte;
    end

endmodule
`default_nettype wire

// ===== rtl/sfpb_back.sv =====
// Reply sequencer: expands queued jobs into result items behind an output register.
`default_nettype none
module sfpb_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_not_empty,
    input  sfpb_pkg::job_t       q_head,
    output logic                 q_pop,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output sfpb_pkg::out_item_t  out_data
);
    import sfpb_pkg::*;

    logic       out_valid_reg;
    out_item_t  out_reg, out_next;
    logic [5:0] pos_reg, pos_next;
    logic [5:0] total;
    logic [5:0] tidx;
    logic       load;
    logic       is_last;
    res_t       r;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign load      = q_not_empty && (!out_valid_reg || !out_stall);
    assign total     = 6'(q_head.n) + tail_len(q_head.tail);
    assign is_last   = (pos_reg == total - 6'd1);
    assign q_pop     = load && is_last;
    assign tidx      = pos_reg - 6'(q_head.n);

    always_comb
    begin
        if (pos_reg < 6'(q_head.n))
            r = q_head.items[pos_reg[2:0]];
        else if (q_head.tail == TAIL_MAP)
            r = '{KIND_HOST, map_byte(tidx[4:0])};
        else
            r = '{KIND_HOST, name_byte(tidx[3:0])};
        out_next.out_kind     = r.kind;
        out_next.out_byte     = r.val;
        out_next.clock_select = q_head.clk;
        out_next.last         = is_last;
        pos_next = pos_reg;
        if (load)
            pos_next = is_last ? 6'd0 : pos_reg + 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

endmodule
`default_nettype wire

// ===== rtl/serial_flash_programmer_bridge.sv =====
// Top level: serprog command bridge between a host byte link and an SPI shifter.
// An event passes through the decode front in order: the write buffer read at the transfer,
// then the decode, so no new event is taken during a decode or while the reply queue is full.
// Each event is decoded, queued as a reply job and loaded into the output register; replies
// then leave one per cycle while out_stall is low, up to 33 per event.
// Reset (rst_n low, asynchronous): idle, chip select high, 18 MHz clock, timeout 200 ticks.
`default_nettype none
module serial_flash_programmer_bridge #(
    parameter int WRITE_DEPTH = 1024,
    parameter int READ_LIMIT  = 4096
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  sfpb_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output sfpb_pkg::out_item_t  out_data,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [15:0]     cfg_data
);
    import sfpb_pkg::*;

    logic q_push, q_full, q_pop, q_not_empty;
    job_t q_data, q_head;

    sfpb_front #(
        .WRITE_DEPTH(WRITE_DEPTH),
        .READ_LIMIT (READ_LIMIT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_data)
    );

    sfpb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_data),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .not_empty(q_not_empty)
    );

    sfpb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_not_empty(q_not_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
`default_nettype wire

// ===== rtl/sfpb_checker.sv =====
// Port-level checks for the bridge, bound to the top level.
`default_nettype none
module sfpb_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_stall,
    input  wire logic            out_valid,
    input  wire logic            out_stall,
    input  sfpb_pkg::out_item_t  out_data
);
    import sfpb_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("stalled result changed");

    a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("event taken before decode finished");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.out_kind != 2'd3)
        else $error("bad result kind");

    a_cs_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_kind == KIND_CS |-> out_data.out_byte[7:1] == 7'd0)
        else $error("chip select level not 0 or 1");

endmodule

bind serial_flash_programmer_bridge sfpb_checker u_sfpb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);
`default_nettype wire

// ===== sim/serial_flash_programmer_bridge_tb.sv =====
// Self-checking testbench for the serial flash programmer bridge.
`timescale 1ns / 100ps
`default_nettype none

module serial_flash_programmer_bridge_tb;
    import sfpb_pkg::*;

    localparam int WR_DEPTH = 1024;
    localparam int RD_LIMIT = 4096;
    localparam int RANDOM_ITEMS = 370;
    localparam int DRAIN_CYCLES = 80;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PARAM = 2'd1,
        PH_WDATA = 2'd2,
        PH_SPI   = 2'd3
    } phase_t;

    class bridge_scoreboard;
        logic [15:0] timeout_ticks;
        phase_t      phase;
        logic [7:0]  cmd;
        int          pcount;
        logic [47:0] pbytes;
        int          wlen;
        int          rlen;
        int          idx;
        logic [7:0]  wstore [WR_DEPTH];
        int          waited;
        logic        cs_level;
        logic [2:0]  clk_sel;
        out_item_t   expected_q [$];
        int          errors;

        function new();
            timeout_ticks = TIMEOUT_RESET;
            phase = PH_IDLE;
            cmd = 8'd0;
            pcount = 0;
            pbytes = '0;
            wlen = 0;
            rlen = 0;
            idx = 0;
            waited = 0;
            cs_level = 1'b1;
            clk_sel = 3'd1;
            errors = 0;
        endfunction

        function void push(logic [1:0] kind, logic [7:0] val);
            out_item_t r;
            r.out_kind = kind;
            r.out_byte = val;
            r.clock_select = clk_sel;
            r.last = 1'b0;
            expected_q.push_back(r);
        endfunction

        function void push_le(logic [31:0] v, int n);
            for (int i = 0; i < n; i++)
                push(KIND_HOST, v[8*i +: 8]);
        endfunction

        function int param_len(logic [7:0] c);
            case (c)
                CMD_SETBUS:  return 1;
                CMD_OPSPI:   return 6;
                CMD_SPIFREQ: return 4;
                CMD_SPIPIN:  return 2;
                default:     return 0;
            endcase
        endfunction

        function void spi_advance();
            if (idx < wlen)
                push(KIND_SPI, wstore[idx]);
            else if (idx < wlen + rlen)
                push(KIND_SPI, FILL);
            else
            begin
                cs_level = 1'b1;
                push(KIND_CS, 8'd1);
                phase = PH_IDLE;
            end
        endfunction

        function void spi_begin();
            push(KIND_HOST, RESP_ACK);
            cs_level = 1'b0;
            push(KIND_CS, 8'd0);
            idx = 0;
            phase = PH_SPI;
            spi_advance();
        endfunction

        function void execute(logic [7:0] c);
            logic [31:0] rate;
            logic [7:0] name [16];
            name = '{8'h75, 8'h6E, 8'h69, 8'h2D, 8'h73, 8'h65, 8'h72, 8'h70,
                     8'h72, 8'h6F, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            phase = PH_IDLE;
            case (c)
                CMD_NOP: push(KIND_HOST, RESP_ACK);
                CMD_IFACE:
                begin
                    push(KIND_HOST, RESP_ACK);
                    push(KIND_HOST, 8'h01);
                    push(KIND_HOST, 8'h00);
                end
                CMD_CMDMAP:
                begin
                    push(KIND_HOST, RESP_ACK);
                    push(KIND_HOST, 8'hBF);
                    push(KIND_HOST, 8'h80);
                    push(KIND_HOST, 8'h0F);
                    for (int i = 3; i < 32; i++)
                        push(KIND_HOST, 8'h00);
                end
                CMD_PGMNAME:
                begin
                    push(KIND_HOST, RESP_ACK);
                    for (int i = 0; i < 16; i++)
                        push(KIND_HOST, name[i]);
                end
                CMD_SERBUF:
                begin
                    push(KIND_HOST, RESP_ACK);
                    push_le(RD_LIMIT, 2);
                end
                CMD_BUSTYPE:
                begin
                    push(KIND_HOST, RESP_ACK);
                    push(KIND_HOST, BUS_SPI);
                end
                CMD_WRNMAX:
                begin
                    push(KIND_HOST, RESP_ACK);
                    push_le(WR_DEPTH, 2);
                end
                CMD_RDNMAX:
                begin
                    push(KIND_HOST, RESP_ACK);
                    push_le(RD_LIMIT, 3);
                end
                CMD_SETBUS: push(KIND_HOST, pbytes[3] ? RESP_ACK : RESP_NAK);
                CMD_OPSPI:
                begin
                    wlen = int'(pbytes[23:0]);
                    rlen = int'(pbytes[47:24]);
                    if (wlen > WR_DEPTH || rlen > RD_LIMIT)
                    begin
                        wlen = 0;
                        rlen = 0;
                        push(KIND_HOST, RESP_NAK);
                    end
                    else if (wlen > 0)
                    begin
                        idx = 0;
                        waited = 0;
                        phase = PH_WDATA;
                    end
                    else
                        spi_begin();
                end
                CMD_SPIFREQ:
                begin
                    rate = pbytes[31:0];
                    clk_sel = 3'd7;
                    for (int i = 0; i < 8; i++)
                    begin
                        if ((BASE_RATE >> i) <= rate)
                        begin
                            clk_sel = 3'(i);
                            break;
                        end
                    end
                    push(KIND_HOST, RESP_ACK);
                    push_le(BASE_RATE >> clk_sel, 4);
                end
                CMD_SPIPIN:
                begin
                    if (pbytes[7:0] == 8'd0)
                    begin
                        cs_level = (pbytes[15:8] != 8'd0);
                        push(KIND_CS, {7'd0, cs_level});
                    end
                    push(KIND_HOST, RESP_ACK);
                end
                default: push(KIND_HOST, RESP_NAK);
            endcase
        endfunction

        // work out every result one accepted transfer causes
        function void note_input(in_item_t it);
            int prior_size;
            prior_size = expected_q.size();
            if (it.action == ACT_HOST)
            begin
                if (phase == PH_IDLE)
                begin
                    cmd = it.in_byte;
                    if (param_len(it.in_byte) > 0)
                    begin
                        pcount = 0;
                        pbytes = '0;
                        waited = 0;
                        phase = PH_PARAM;
                    end
                    else
                        execute(it.in_byte);
                end
                else if (phase == PH_PARAM)
                begin
                    if (pcount < 6)
                        pbytes[8*pcount +: 8] = it.in_byte;
                    pcount++;
                    waited = 0;
                    if (pcount >= param_len(cmd))
                        execute(cmd);
                end
                else if (phase == PH_WDATA)
                begin
                    if (idx < WR_DEPTH)
                        wstore[idx] = it.in_byte;
                    idx++;
                    waited = 0;
                    if (idx >= wlen)
                        spi_begin();
                end
            end
            else if (it.action == ACT_SPI)
            begin
                if (phase == PH_SPI)
                begin
                    if (idx >= wlen)
                        push(KIND_HOST, it.in_byte);
                    idx++;
                    spi_advance();
                end
            end
            else if (it.action == ACT_TICK)
            begin
                if (phase == PH_PARAM || phase == PH_WDATA)
                begin
                    if (waited < 16'hFFFF)
                        waited++;
                    if (waited >= timeout_ticks)
                    begin
                        push(KIND_HOST, RESP_NAK);
                        phase = PH_IDLE;
                        waited = 0;
                    end
                end
            end
            if (expected_q.size() > prior_size)
                expected_q[expected_q.size() - 1].last = 1'b1;
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.out_kind !== want.out_kind)
            begin
                $display("%0t: out_kind expected %0d actual %0d", $realtime,
                         want.out_kind, got.out_kind);
                errors++;
            end
            if (got.out_byte !== want.out_byte)
            begin
                $display("%0t: out_byte expected %h actual %h", $realtime,
                         want.out_byte, got.out_byte);
                errors++;
            end
            if (got.clock_select !== want.clock_select)
            begin
                $display("%0t: clock_select expected %0d actual %0d", $realtime,
                         want.clock_select, got.clock_select);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last expected %0d actual %0d", $realtime,
                         want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    bridge_scoreboard sb;
    int burst_left;
    int sent;

    serial_flash_programmer_bridge dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("serial_flash_programmer_bridge regression: fail");
        $finish;
    end

    // receiver: stall pattern in stretches of a randomly chosen mode, quiet or busy
    int stall_mode;
    int stall_left;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(out_data);
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(5, 60);
            end
            stall_left--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    task automatic send(logic [1:0] act, logic [7:0] b);
        in_item_t it;
        it.action = act;
        it.in_byte = b;
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(it);
        sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    task automatic host(logic [7:0] b);
        send(ACT_HOST, b);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_timeout(logic [15:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.timeout_ticks = v;
    endtask

    // complete SPI operation with host-side returns
    task automatic spi_op(int wl, int rl);
        host(CMD_OPSPI);
        host(wl[7:0]); host(wl[15:8]); host(wl[23:16]);
        host(rl[7:0]); host(rl[15:8]); host(rl[23:16]);
        for (int i = 0; i < wl; i++)
            host(8'($urandom_range(0, 255)));
        for (int i = 0; i < wl + rl; i++)
            send(ACT_SPI, 8'($urandom_range(0, 255)));
    endtask

    task automatic maybe_tick();
        if ($urandom_range(0, 9) == 0)
            send(ACT_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic random_sequence();
        int r;
        logic [7:0] c;
        logic [7:0] cmds [13];
        cmds = '{CMD_NOP, CMD_IFACE, CMD_CMDMAP, CMD_PGMNAME, CMD_SERBUF,
                 CMD_BUSTYPE, CMD_WRNMAX, CMD_RDNMAX, CMD_SETBUS, CMD_OPSPI,
                 CMD_SPIFREQ, CMD_SPIPIN, 8'h06};
        r = $urandom_range(0, 99);
        if (r < 12)
            send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        else if (r < 16)
            host(8'($urandom_range(0, 255)));
        else
        begin
            c = cmds[$urandom_range(0, 12)];
            if (c == CMD_OPSPI)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // random length bytes, mostly oversized
                    host(c);
                    repeat (6)
                    begin
                        host(8'($urandom_range(0, 255)));
                        maybe_tick();
                    end
                end
                else
                    spi_op($urandom_range(0, 6), $urandom_range(0, 6));
            end
            else
            begin
                host(c);
                repeat (sb.param_len(c))
                begin
                    maybe_tick();
                    case (c)
                        CMD_SPIPIN: host($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255)));
                        default:    host(8'($urandom_range(0, 255)));
                    endcase
                end
            end
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        stall_left = 0;
        stall_mode = 0;
        burst_left = 4;
        sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every query, unknown code, stray events, bus, frequency and pin settings
        host(CMD_NOP); host(CMD_IFACE); host(CMD_CMDMAP); host(CMD_PGMNAME);
        host(CMD_SERBUF); host(CMD_BUSTYPE); host(CMD_WRNMAX); host(CMD_RDNMAX);
        host(8'hFF);
        send(ACT_SPI, 8'hA5);
        send(ACT_TICK, 8'h00);
        send(2'd3, 8'h5A);
        host(CMD_SETBUS); host(8'h08);
        host(CMD_SETBUS); host(8'hF7);
        host(CMD_SPIFREQ); host(8'h00); host(8'h00); host(8'h00); host(8'h00);
        host(CMD_SPIPIN); host(8'h00); host(8'h00);
        drain();

        host(CMD_SPIFREQ); host(8'hFF); host(8'hFF); host(8'hFF); host(8'hFF);
        host(CMD_SPIFREQ); host(8'h00); host(8'h09); host(8'h3D); host(8'h00);
        host(CMD_SPIPIN); host(8'h01); host(8'h00);
        host(CMD_SPIPIN); host(8'h00); host(8'hFF);
        spi_op(0, 0);
        spi_op(3, 2);
        // write length above the buffer, then read length above the limit
        host(CMD_OPSPI); host(8'h01); host(8'h04); host(8'h00);
        host(8'h00); host(8'h00); host(8'h00);
        host(CMD_OPSPI); host(8'h00); host(8'h00); host(8'h00);
        host(8'h01); host(8'h10); host(8'h00);
        drain();

        // timeouts at short settings
        set_timeout(16'd1);
        host(CMD_SPIFREQ); send(ACT_TICK, 8'h00);
        host(CMD_OPSPI); host(8'h02); host(8'h00); host(8'h00);
        host(8'h00); host(8'h00); host(8'h00); host(8'h11);
        send(ACT_TICK, 8'h00);
        set_timeout(16'd3);
        host(CMD_SETBUS); send(ACT_TICK, 8'h00); send(ACT_TICK, 8'h00);
        send(ACT_TICK, 8'h00);

        set_timeout(16'hFFFF);
        // longer operations once each
        spi_op(24, 8);
        spi_op(0, 32);

        while (sent < RANDOM_ITEMS)
        begin
            if (sent > 120 && sb.timeout_ticks == 16'hFFFF)
                set_timeout(16'd2);
            else if (sent > 250 && sb.timeout_ticks == 16'd2)
                set_timeout(16'($urandom_range(4, 40)));
            random_sequence();
        end

        drain();
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("serial_flash_programmer_bridge regression: pass");
        else
            $display("serial_flash_programmer_bridge regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== serial_flash_programmer_bridge.f =====
rtl/sfpb_pkg.sv
rtl/sfpb_queue.sv
rtl/sfpb_front.sv
rtl/sfpb_back.sv
rtl/serial_flash_programmer_bridge.sv
rtl/sfpb_checker.sv
sim/serial_flash_programmer_bridge_tb.sv
